>>> rtl/grp_pkg.sv
// ----------------------------------------------------------------------------
// grp_pkg
// Shared types, field widths and status codes for the guillotine rectangle
// packer.
// ----------------------------------------------------------------------------
package grp_pkg;

    // Field widths of the transfer payloads
    localparam int SPRITE_W = 12;
    localparam int POS_W    = 14;
    localparam int SIZE_W   = 15;

    // Default configuration
    localparam int FREE_SLOTS_DEF = 64;
    localparam int MAX_SIDE_DEF   = 16384;

    typedef logic [SPRITE_W-1:0] t_sprite;
    typedef logic [POS_W-1:0]    t_pos;
    typedef logic [SIZE_W-1:0]   t_size;

    typedef enum logic [1:0] {
        ST_PLACED    = 2'd0,
        ST_FULL      = 2'd1,
        ST_TOO_LARGE = 2'd2
    } t_status;

    typedef struct packed {
        logic    new_atlas;
        t_sprite sprite_width;
        t_sprite sprite_height;
    } t_in;

    typedef struct packed {
        t_pos    place_x;
        t_pos    place_y;
        t_size   atlas_width;
        t_size   atlas_height;
        t_status status;
    } t_out;

    typedef enum logic [3:0] {
        S_IDLE,
        S_START,
        S_SCAN,
        S_GROW,
        S_GCHK,
        S_PLACE,
        S_PUSH_R,
        S_PUSH_B,
        S_EMIT
    } t_state;

endpackage

>>> rtl/guillotine_rect_packer.sv
// ----------------------------------------------------------------------------
// guillotine_rect_packer
// First-fit guillotine packer: places one rectangle per transfer into a
// growing atlas and returns its position, the atlas size and a status.
// ----------------------------------------------------------------------------
// An item that takes a free-table entry appends zero to two remainders to
// the table. When none of the N entries fits, the atlas is doubled, each
// doubling appending one growth strip; a new-atlas item needs no scan.
// Other items start with a scan of the free table, which reads one entry
// per cycle from the free-table memory and tests it in one shared fit
// comparator; remainders are then written one per cycle, and growth strips
// one per doubling, through the same memory's write port. The block takes
// no new item until the result of the current one is loaded into the output
// register; a finished result may wait there while the next item is already
// being worked on. A failed item (table full or atlas too large) leaves the
// table and atlas size as they were and reports position (0,0).
module guillotine_rect_packer #(
    parameter int FREE_SLOTS = grp_pkg::FREE_SLOTS_DEF,
    parameter int MAX_SIDE   = grp_pkg::MAX_SIDE_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  grp_pkg::t_in  i_data,
    output logic          o_valid,
    input  logic          i_ready,
    output grp_pkg::t_out o_data
);

    import grp_pkg::*;

    localparam int CW   = $clog2(MAX_SIDE);
    localparam int SW   = $clog2(MAX_SIDE + 1);
    localparam int SW1  = SW + 1;
    localparam int WW   = ((SW > SPRITE_W) ? SW : SPRITE_W) + 1;
    localparam int IDXW = $clog2(FREE_SLOTS);
    localparam int CNTW = $clog2(FREE_SLOTS + 1);
    localparam int CNT1 = CNTW + 1;

    typedef struct packed {
        logic [CW-1:0] left;
        logic [CW-1:0] top;
        logic [SW-1:0] width;
        logic [SW-1:0] height;
        logic          taken;
    } t_entry;

    localparam int ENT_W = $bits(t_entry);

    // Control state
    t_state          r_state,   n_state;
    logic [CNTW-1:0] r_count,   n_count;
    logic [SW-1:0]   r_cur_w,   n_cur_w;
    logic [SW-1:0]   r_cur_h,   n_cur_h;
    logic            r_chk_vld, n_chk_vld;
    logic            r_out_valid, n_out_valid;

    // Working data
    t_in             r_in,      n_in;
    logic [CNTW-1:0] r_wcnt,    n_wcnt;
    logic [SW-1:0]   r_ww,      n_ww;
    logic [SW-1:0]   r_wh,      n_wh;
    logic [CNTW-1:0] r_rd_idx,  n_rd_idx;
    logic [IDXW-1:0] r_chk_idx, n_chk_idx;
    t_entry          r_ent,     n_ent;
    logic [IDXW-1:0] r_ent_idx, n_ent_idx;
    logic            r_need_b,  n_need_b;
    logic [CW-1:0]   r_res_x,   n_res_x;
    logic [CW-1:0]   r_res_y,   n_res_y;
    t_status         r_res_st,  n_res_st;
    t_out            r_out,     n_out;

    // Memory ports
    logic             w_we;
    logic [IDXW-1:0]  w_waddr;
    t_entry           w_wentry;
    logic             w_re;
    logic [IDXW-1:0]  w_raddr;
    logic [ENT_W-1:0] w_rdata;

    // Shared fit test and placement arithmetic
    t_entry          w_cand;
    logic            w_fit;
    logic [WW-1:0]   w_sw;
    logic [WW-1:0]   w_sh;
    logic            w_need_r;
    logic            w_need_b;
    logic [CNT1-1:0] w_need_sum;
    logic [SW1-1:0]  w_dbl;
    logic [WW-1:0]   w_nw;
    logic [WW-1:0]   w_nh;

    grp_free_mem #(
        .DEPTH  (FREE_SLOTS),
        .DATA_W (ENT_W)
    ) u_free_mem (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wentry),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // Fit comparator: memory data while scanning, held entry otherwise
    always_comb begin
        w_sw   = WW'(r_in.sprite_width);
        w_sh   = WW'(r_in.sprite_height);
        w_cand = (r_state == S_SCAN) ? t_entry'(w_rdata) : r_ent;
        w_fit  = !w_cand.taken && (w_sw <= WW'(w_cand.width))
                 && (w_sh <= WW'(w_cand.height));
        w_need_r   = (WW'(r_ent.width) > w_sw) && (r_ent.height != '0);
        w_need_b   = (w_sw != '0) && (WW'(r_ent.height) > w_sh);
        w_need_sum = CNT1'(r_wcnt) + CNT1'(w_need_r) + CNT1'(w_need_b);
        w_dbl      = (r_ww > r_wh) ? {r_wh, 1'b0} : {r_ww, 1'b0};
        w_nw       = (w_sw == '0) ? WW'(1) : w_sw;
        w_nh       = (w_sh == '0) ? WW'(1) : w_sh;
    end

    // Sequencer: next state, working registers and memory access
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_cur_w     = r_cur_w;
        n_cur_h     = r_cur_h;
        n_chk_vld   = 1'b0;
        n_out_valid = r_out_valid & ~i_ready;
        n_in        = r_in;
        n_wcnt      = r_wcnt;
        n_ww        = r_ww;
        n_wh        = r_wh;
        n_rd_idx    = r_rd_idx;
        n_chk_idx   = r_chk_idx;
        n_ent       = r_ent;
        n_ent_idx   = r_ent_idx;
        n_need_b    = r_need_b;
        n_res_x     = r_res_x;
        n_res_y     = r_res_y;
        n_res_st    = r_res_st;
        n_out       = r_out;
        w_we        = 1'b0;
        w_waddr     = r_wcnt[IDXW-1:0];
        w_wentry    = r_ent;
        w_re        = 1'b0;
        w_raddr     = r_rd_idx[IDXW-1:0];
        o_ready     = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    n_in    = i_data;
                    n_state = S_START;
                end
            end

            // Start a new atlas, or copy the committed state and scan
            S_START: begin
                n_wcnt   = r_count;
                n_ww     = r_cur_w;
                n_wh     = r_cur_h;
                n_rd_idx = '0;
                n_res_x  = '0;
                n_res_y  = '0;
                if (r_in.new_atlas) begin
                    n_state = S_EMIT;
                    if (w_nw > WW'(MAX_SIDE) || w_nh > WW'(MAX_SIDE)) begin
                        n_res_st = ST_TOO_LARGE;
                    end else begin
                        n_res_st = ST_PLACED;
                        n_ww     = SW'(w_nw);
                        n_wh     = SW'(w_nh);
                        n_wcnt   = '0;
                    end
                end else begin
                    n_state = S_SCAN;
                end
            end

            // Issue one read per cycle, test the entry read in the previous cycle
            S_SCAN: begin
                if (r_chk_vld && w_fit) begin
                    n_ent     = w_cand;
                    n_ent_idx = r_chk_idx;
                    n_state   = S_PLACE;
                end else if (r_rd_idx < r_wcnt) begin
                    w_re      = 1'b1;
                    n_rd_idx  = r_rd_idx + 1'b1;
                    n_chk_vld = 1'b1;
                    n_chk_idx = r_rd_idx[IDXW-1:0];
                end else if (!r_chk_vld) begin
                    n_state = S_GROW;
                end
            end

            // Double the smaller side, add its strip; fail if full or too large
            S_GROW: begin
                if (r_wcnt >= CNTW'(FREE_SLOTS)) begin
                    n_res_st = ST_FULL;
                    n_state  = S_EMIT;
                end else if (w_dbl > SW1'(MAX_SIDE)) begin
                    n_res_st = ST_TOO_LARGE;
                    n_state  = S_EMIT;
                end else begin
                    if (r_ww > r_wh) begin
                        w_wentry = '{left: '0, top: CW'(r_wh), width: r_ww,
                                     height: r_wh, taken: 1'b0};
                        n_wh     = SW'(w_dbl);
                    end else begin
                        w_wentry = '{left: CW'(r_ww), top: '0, width: r_ww,
                                     height: r_wh, taken: 1'b0};
                        n_ww     = SW'(w_dbl);
                    end
                    w_we      = 1'b1;
                    n_ent     = w_wentry;
                    n_ent_idx = r_wcnt[IDXW-1:0];
                    n_wcnt    = r_wcnt + 1'b1;
                    n_state   = S_GCHK;
                end
            end

            // Only the new strip can fit after growth
            S_GCHK: begin
                n_state = w_fit ? S_PLACE : S_GROW;
            end

            // Mark the chosen entry taken unless the remainders overflow
            S_PLACE: begin
                if (w_need_sum > CNT1'(FREE_SLOTS)) begin
                    n_res_st = ST_FULL;
                    n_state  = S_EMIT;
                end else begin
                    w_we           = 1'b1;
                    w_waddr        = r_ent_idx;
                    w_wentry       = r_ent;
                    w_wentry.taken = 1'b1;
                    n_res_x        = r_ent.left;
                    n_res_y        = r_ent.top;
                    n_res_st       = ST_PLACED;
                    n_need_b       = w_need_b;
                    if (w_need_r) begin
                        n_state = S_PUSH_R;
                    end else if (w_need_b) begin
                        n_state = S_PUSH_B;
                    end else begin
                        n_state = S_EMIT;
                    end
                end
            end

            // Append the right remainder
            S_PUSH_R: begin
                w_we     = 1'b1;
                w_wentry = '{left: CW'(WW'(r_ent.left) + w_sw), top: r_ent.top,
                             width: SW'(WW'(r_ent.width) - w_sw),
                             height: r_ent.height, taken: 1'b0};
                n_wcnt   = r_wcnt + 1'b1;
                n_state  = r_need_b ? S_PUSH_B : S_EMIT;
            end

            // Append the below remainder
            S_PUSH_B: begin
                w_we     = 1'b1;
                w_wentry = '{left: r_ent.left, top: CW'(WW'(r_ent.top) + w_sh),
                             width: SW'(w_sw),
                             height: SW'(WW'(r_ent.height) - w_sh), taken: 1'b0};
                n_wcnt   = r_wcnt + 1'b1;
                n_state  = S_EMIT;
            end

            // Load the output register; commit working state on success
            S_EMIT: begin
                if (!r_out_valid || i_ready) begin
                    n_out_valid      = 1'b1;
                    n_out.place_x    = t_pos'(r_res_x);
                    n_out.place_y    = t_pos'(r_res_y);
                    n_out.status     = r_res_st;
                    if (r_res_st == ST_PLACED) begin
                        n_count            = r_wcnt;
                        n_cur_w            = r_ww;
                        n_cur_h            = r_wh;
                        n_out.atlas_width  = t_size'(r_ww);
                        n_out.atlas_height = t_size'(r_wh);
                    end else begin
                        n_out.place_x      = '0;
                        n_out.place_y      = '0;
                        n_out.atlas_width  = t_size'(r_cur_w);
                        n_out.atlas_height = t_size'(r_cur_h);
                    end
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_cur_w     <= SW'(1);
            r_cur_h     <= SW'(1);
            r_chk_vld   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_cur_w     <= n_cur_w;
            r_cur_h     <= n_cur_h;
            r_chk_vld   <= n_chk_vld;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_in      <= n_in;
        r_wcnt    <= n_wcnt;
        r_ww      <= n_ww;
        r_wh      <= n_wh;
        r_rd_idx  <= n_rd_idx;
        r_chk_idx <= n_chk_idx;
        r_ent     <= n_ent;
        r_ent_idx <= n_ent_idx;
        r_need_b  <= n_need_b;
        r_res_x   <= n_res_x;
        r_res_y   <= n_res_y;
        r_res_st  <= n_res_st;
        r_out     <= n_out;
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

endmodule

>>> rtl/grp_free_mem.sv
// ----------------------------------------------------------------------------
// grp_free_mem
// Free rectangle table: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module grp_free_mem #(
    parameter int DEPTH  = 64,
    parameter int DATA_W = 59
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [DATA_W-1:0]        i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [DATA_W-1:0]        o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    // Write one entry
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read one entry, hold data while no read is issued
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
